// ===== rtl/core/indexed_block_search_core_macros.svh =====
// Assertion macros for the indexed block search core.
`ifndef INDEXED_BLOCK_SEARCH_CORE_MACROS_SVH
`define INDEXED_BLOCK_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define IBS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ibs: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define IBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ibs: next-cycle check failed");

`endif

// ===== rtl/core/ibs_pkg.sv =====
package ibs_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int DATA_WIDTH_DEF   = 32;

    localparam int BS_W  = 11;
    localparam int POS_W = 10;
    localparam int OP_W  = 2;

    localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 11'd3;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    typedef struct packed {
        logic append;
        logic clear;
        logic search_init;
        logic bs_issue;
        logic bs_update;
        logic scan_setup;
        logic scan_limit;
        logic scan_issue;
        logic scan_next;
        logic emit_none;
        logic emit_found;
    } ibs_cmd_t;

    typedef struct packed {
        logic lo_lt_hi;
        logic max_lt_key;
        logic lo_ge_bc;
        logic idx_lt_end;
        logic match;
    } ibs_sts_t;

endpackage

// ===== rtl/core/ibs_datapath.sv =====
module ibs_datapath
    import ibs_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ibs_cmd_t                     cmd,
    output ibs_sts_t                     sts,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         block_size_we,
    input  logic [BS_W-1:0]              block_size,
    output logic                         done,
    output logic                         found,
    output logic [POS_W-1:0]             position,
    output logic                         table_full
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic signed [DATA_WIDTH-1:0] elem_mem [MAX_ELEMENTS];
    logic signed [DATA_WIDTH-1:0] max_mem  [MAX_ELEMENTS];

    logic [BS_W-1:0] block_size_reg;
    logic [CW-1:0]   ec_reg;
    logic [CW-1:0]   bc_reg;
    logic [CW-1:0]   fill_reg;
    logic            done_reg;

    logic signed [DATA_WIDTH-1:0] cur_max_reg;
    logic signed [DATA_WIDTH-1:0] key_reg;
    logic signed [DATA_WIDTH-1:0] max_rd_reg;
    logic signed [DATA_WIDTH-1:0] elem_rd_reg;
    logic [CW-1:0]    lo_reg;
    logic [CW-1:0]    hi_reg;
    logic [CW-1:0]    mid_reg;
    logic [CW-1:0]    idx_reg;
    logic [CW-1:0]    end_reg;
    logic             found_reg;
    logic [POS_W-1:0] pos_reg;
    logic             full_reg;

    logic [CW-1:0]      bs_eff;
    logic               ec_full;
    logic [CW:0]        fill_sum;
    logic [CW-1:0]      bc_m1;
    logic [CW-1:0]      mid_calc;
    logic               elem_we;
    logic               max_we;
    logic [AW-1:0]      max_waddr;
    logic [2*CW-1:0]    prod;
    logic [CW:0]        end_sum;
    logic [CW+POS_W-1:0] pos_wide;

    // Block size zero acts as one, oversize is clamped to the table depth.
    always_comb
    begin
        if (block_size_reg == '0)
            bs_eff = CW'(1);
        else if (32'(block_size_reg) > 32'(MAX_ELEMENTS))
            bs_eff = CW'(MAX_ELEMENTS);
        else
            bs_eff = CW'(block_size_reg);
    end

    assign ec_full   = (ec_reg == CW'(MAX_ELEMENTS));
    assign fill_sum  = {1'b0, fill_reg} + (CW+1)'(1);
    assign bc_m1     = bc_reg - CW'(1);
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign elem_we   = cmd.append && !ec_full;
    assign max_we    = elem_we && ((fill_reg == '0) || (value > cur_max_reg));
    assign max_waddr = (fill_reg == '0) ? bc_reg[AW-1:0] : bc_m1[AW-1:0];
    assign prod      = lo_reg * bs_eff;
    assign end_sum   = {1'b0, idx_reg} + {1'b0, bs_eff};
    assign pos_wide  = {{POS_W{1'b0}}, idx_reg};

    assign sts.lo_lt_hi   = (lo_reg < hi_reg);
    assign sts.max_lt_key = (max_rd_reg < key_reg);
    assign sts.lo_ge_bc   = (lo_reg >= bc_reg);
    assign sts.idx_lt_end = (idx_reg < end_reg);
    assign sts.match      = (elem_rd_reg == key_reg);

    always_ff @(posedge clk)
    begin
        if (elem_we)
            elem_mem[ec_reg[AW-1:0]] <= value;
        if (cmd.scan_issue)
            elem_rd_reg <= elem_mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (max_we)
            max_mem[max_waddr] <= value;
        if (cmd.bs_issue)
            max_rd_reg <= max_mem[mid_calc[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RST;
            ec_reg         <= '0;
            bc_reg         <= '0;
            fill_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.append || cmd.emit_none || cmd.emit_found;
            if (block_size_we)
            begin
                block_size_reg <= block_size;
                ec_reg         <= '0;
                bc_reg         <= '0;
                fill_reg       <= '0;
            end
            else if (cmd.clear)
            begin
                ec_reg   <= '0;
                bc_reg   <= '0;
                fill_reg <= '0;
            end
            else if (elem_we)
            begin
                ec_reg <= ec_reg + CW'(1);
                if (fill_reg == '0)
                    bc_reg <= bc_reg + CW'(1);
                if (fill_sum >= {1'b0, bs_eff})
                    fill_reg <= '0;
                else
                    fill_reg <= fill_sum[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (max_we)
            cur_max_reg <= value;
        if (cmd.search_init)
        begin
            key_reg <= value;
            lo_reg  <= '0;
            hi_reg  <= bc_reg;
        end
        if (cmd.bs_issue)
            mid_reg <= mid_calc;
        if (cmd.bs_update)
        begin
            if (sts.max_lt_key)
                lo_reg <= mid_reg + CW'(1);
            else
                hi_reg <= mid_reg;
        end
        if (cmd.scan_setup)
            idx_reg <= prod[CW-1:0];
        if (cmd.scan_limit)
            end_reg <= (end_sum > {1'b0, ec_reg}) ? ec_reg : end_sum[CW-1:0];
        if (cmd.scan_next)
            idx_reg <= idx_reg + CW'(1);
        if (cmd.append)
        begin
            found_reg <= 1'b0;
            pos_reg   <= '0;
            full_reg  <= ec_full;
        end
        if (cmd.emit_none)
        begin
            found_reg <= 1'b0;
            pos_reg   <= '0;
            full_reg  <= 1'b0;
        end
        if (cmd.emit_found)
        begin
            found_reg <= 1'b1;
            pos_reg   <= pos_wide[POS_W-1:0];
            full_reg  <= 1'b0;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign position   = pos_reg;
    assign table_full = full_reg;

endmodule

// ===== rtl/core/ibs_ctrl.sv =====
module ibs_ctrl
    import ibs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OP_W-1:0] opcode,
    input  ibs_sts_t        sts,
    output ibs_cmd_t        cmd,
    output logic            busy
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_BS_ISSUE   = 3'd1;
    localparam logic [2:0] ST_BS_CMP     = 3'd2;
    localparam logic [2:0] ST_SCAN_SETUP = 3'd3;
    localparam logic [2:0] ST_SCAN_LIMIT = 3'd4;
    localparam logic [2:0] ST_SCAN_ISSUE = 3'd5;
    localparam logic [2:0] ST_SCAN_CMP   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        OP_APPEND: cmd.append = 1'b1;
                        OP_SEARCH:
                        begin
                            cmd.search_init = 1'b1;
                            state_next      = ST_BS_ISSUE;
                        end
                        OP_CLEAR:  cmd.clear = 1'b1;
                        default:   ;
                    endcase
                end
            end
            ST_BS_ISSUE:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.bs_issue = 1'b1;
                    state_next   = ST_BS_CMP;
                end
                else
                    state_next = ST_SCAN_SETUP;
            end
            ST_BS_CMP:
            begin
                cmd.bs_update = 1'b1;
                state_next    = ST_BS_ISSUE;
            end
            ST_SCAN_SETUP:
            begin
                if (sts.lo_ge_bc)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.scan_setup = 1'b1;
                    state_next     = ST_SCAN_LIMIT;
                end
            end
            ST_SCAN_LIMIT:
            begin
                cmd.scan_limit = 1'b1;
                state_next     = ST_SCAN_ISSUE;
            end
            ST_SCAN_ISSUE:
            begin
                if (sts.idx_lt_end)
                begin
                    cmd.scan_issue = 1'b1;
                    state_next     = ST_SCAN_CMP;
                end
                else
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    cmd.emit_found = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/core/indexed_block_search_core.sv =====
// Indexed block search. An item is taken when start is high and busy is low; the
// result of an append or a search appears one cycle after the work ends, on done
// for a single cycle, and must be taken then since there is no stall. Append,
// clear and no-op never raise busy. In a search, each halving step and each
// scanned element has a read step, which loads the block-maximum or element
// memory word into a register, and a compare step, which compares the registered
// read data. Writing block_size empties the table.
module indexed_block_search_core
    import ibs_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [OP_W-1:0]              opcode,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         block_size_we,
    input  logic [BS_W-1:0]              block_size,
    output logic                         done,
    output logic                         found,
    output logic [POS_W-1:0]             position,
    output logic                         table_full
);

    ibs_cmd_t cmd;
    ibs_sts_t sts;

    ibs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    ibs_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .DATA_WIDTH   (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .value         (value),
        .block_size_we (block_size_we),
        .block_size    (block_size),
        .done          (done),
        .found         (found),
        .position      (position),
        .table_full    (table_full)
    );

endmodule

// ===== rtl/core/ibs_checker.sv =====
`include "indexed_block_search_core_macros.svh"

module ibs_checker
    import ibs_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic [OP_W-1:0] opcode,
    input logic            done,
    input logic            found,
    input logic            table_full
);

    logic take;

    assign take = start && !busy;

    `IBS_ASSERT_NEXT(a_append_result, take && (opcode == OP_APPEND), done && !busy)
    `IBS_ASSERT_NEXT(a_search_busy, take && (opcode == OP_SEARCH), busy && !done)
    `IBS_ASSERT_NEXT(a_quiet_ops, take && ((opcode == OP_CLEAR) || (opcode == OP_NOP)), !done)
    `IBS_ASSERT_NOW(a_found_not_full, done && found, !table_full)

endmodule

bind indexed_block_search_core ibs_checker u_ibs_checker (.*);
